[hw/rtl/plt_pkg.sv]
// shared types and constants for the palette interpolating lookup
// no dependencies; used by every module of the block and by its checker
package plt_pkg;

    localparam int MAX_ENTRIES_DEF = 256;

    // input and result channel widths
    localparam int IDX_W   = 32;
    localparam int RGB_W   = 24;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    localparam logic [RGB_W-1:0] WHITE = 24'hFF_FFFF;

    // modulo unit: 23-bit entry number padded to 24, two quotient bits a cycle
    localparam int DIV_BITS  = 24;
    localparam int DIV_RADIX = 2;
    localparam int DIV_STEPS = DIV_BITS / DIV_RADIX;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_GET    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

endpackage

[hw/rtl/palette_interpolating_lookup.sv]
// palette interpolating lookup: top level with command sequencer and output register
// depends on plt_pkg, plt_ram, plt_mod and plt_blend
//
// usage
//   s_ channel: one command per transfer. s_tuser holds the command (append,
//   change, lookup, get); s_tdata holds the signed entry number or 8-bit
//   fraction palette position in bits 31:0 and the colour in bits 55:32.
//   m_ channel: exactly one result per command. m_tdata holds red, green and
//   blue from the low byte up; m_tuser holds the status.
//   commands run one at a time. append, change and reads of an empty palette
//   or a bad index go from decode straight to the done state; a get and a
//   lookup at a negative position first take the word read from memory. an
//   interpolated lookup waits on the radix-4 modulo unit wrapping the entry
//   number by the entry count, then makes the back-to-back reads of the
//   single palette memory port and blends the two entries. s_tready returns
//   in the cycle after the result is loaded.
//   a finished result waits in the output register; the next command is
//   taken meanwhile, and its result is held back until the register drains.
//   reset empties the palette (count to zero) and drops any pending result;
//   memory contents are not cleared, entries are only read once appended.
module palette_interpolating_lookup #(
    parameter int MAX_ENTRIES = plt_pkg::MAX_ENTRIES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plt_pkg::S_DATA_W-1:0]  s_tdata,   // index[31:0], rgb_in[55:32]
    input  logic [1:0]                    s_tuser,   // cmd[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plt_pkg::M_DATA_W-1:0]  m_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic [1:0]                    m_tuser    // status[1:0]
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_RD2,
        S_BLEND,
        S_BLENDW,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 count_reg;
    plt_pkg::cmd_t                 cmd_reg;
    logic [plt_pkg::IDX_W-1:0]     idx_reg;
    logic [plt_pkg::RGB_W-1:0]     rgb_reg;
    logic [AW-1:0]                 e1_reg;
    logic [plt_pkg::RGB_W-1:0]     c1_reg;
    logic [plt_pkg::RGB_W-1:0]     res_rgb_reg;
    plt_pkg::status_t              res_st_reg;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [plt_pkg::M_DATA_W-1:0]  m_tdata_reg;
    plt_pkg::status_t              m_tuser_reg;

    logic                          mem_we;
    logic [AW-1:0]                 mem_addr;
    logic [plt_pkg::RGB_W-1:0]     mem_rdata;
    logic                          div_start;
    logic                          div_done;
    logic [CW-1:0]                 div_rem;
    logic [plt_pkg::RGB_W-1:0]     blend_rgb;
    logic [CW-1:0]                 e2_inc;
    logic [AW-1:0]                 e2;
    logic                          is_full;
    logic                          is_empty;
    logic                          idx_bad;
    logic                          out_free;

    assign is_full  = (count_reg == CW'(MAX_ENTRIES));
    assign is_empty = (count_reg == '0);
    assign idx_bad  = idx_reg[31] || ({1'b0, idx_reg[30:0]} >= 32'(count_reg));
    assign out_free = !m_tvalid_reg || m_tready;

    // result register loads from the done state, otherwise clears on its transfer
    assign m_tvalid_next = ((state_reg == S_DONE) && out_free) || (m_tvalid_reg && !m_tready);

    // next entry wraps to zero past the last one
    assign e2_inc = CW'(e1_reg) + CW'(1);
    assign e2     = (e2_inc == count_reg) ? '0 : e2_inc[AW-1:0];

    assign div_start = (state_reg == S_DECODE) && (cmd_reg == plt_pkg::CMD_LOOKUP)
                       && !is_empty && !idx_reg[31];

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = '0;
        case (state_reg)
            S_DECODE: begin
                case (cmd_reg)
                    plt_pkg::CMD_APPEND: begin
                        mem_we   = !is_full;
                        mem_addr = count_reg[AW-1:0];
                    end
                    plt_pkg::CMD_CHANGE: begin
                        mem_we   = !idx_bad;
                        mem_addr = idx_reg[AW-1:0];
                    end
                    plt_pkg::CMD_GET: begin
                        mem_addr = idx_reg[AW-1:0];
                    end
                    plt_pkg::CMD_LOOKUP: begin
                        // negative position reads the last entry
                        mem_addr = AW'(count_reg - CW'(1));
                    end
                    default: begin
                        mem_addr = '0;
                    end
                endcase
            end
            S_DIV:   mem_addr = div_rem[AW-1:0];
            S_RD2:   mem_addr = e2;
            default: mem_addr = '0;
        endcase
    end

    plt_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (rgb_reg),
        .rdata (mem_rdata)
    );

    plt_mod #(
        .CW (CW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({1'b0, idx_reg[30:8]}),
        .divisor  (count_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    plt_blend u_blend (
        .aclk (aclk),
        .c1   (c1_reg),
        .c2   (mem_rdata),
        .frac (idx_reg[7:0]),
        .rgb  (blend_rgb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg   <= plt_pkg::cmd_t'(s_tuser);
                        idx_reg   <= s_tdata[31:0];
                        rgb_reg   <= s_tdata[55:32];
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    case (cmd_reg)
                        plt_pkg::CMD_APPEND: begin
                            res_rgb_reg <= '0;
                            state_reg   <= S_DONE;
                            if (is_full) begin
                                res_st_reg <= plt_pkg::ST_FULL;
                            end else begin
                                res_st_reg <= plt_pkg::ST_OK;
                                count_reg  <= count_reg + CW'(1);
                            end
                        end
                        plt_pkg::CMD_CHANGE: begin
                            res_rgb_reg <= '0;
                            res_st_reg  <= idx_bad ? plt_pkg::ST_RANGE : plt_pkg::ST_OK;
                            state_reg   <= S_DONE;
                        end
                        plt_pkg::CMD_GET: begin
                            res_rgb_reg <= plt_pkg::WHITE;
                            if (is_empty) begin
                                res_st_reg <= plt_pkg::ST_EMPTY;
                                state_reg  <= S_DONE;
                            end else if (idx_bad) begin
                                res_st_reg <= plt_pkg::ST_RANGE;
                                state_reg  <= S_DONE;
                            end else begin
                                res_st_reg <= plt_pkg::ST_OK;
                                state_reg  <= S_BLENDW;
                            end
                        end
                        plt_pkg::CMD_LOOKUP: begin
                            res_rgb_reg <= plt_pkg::WHITE;
                            if (is_empty) begin
                                res_st_reg <= plt_pkg::ST_EMPTY;
                                state_reg  <= S_DONE;
                            end else begin
                                res_st_reg <= plt_pkg::ST_OK;
                                state_reg  <= idx_reg[31] ? S_BLENDW : S_DIV;
                            end
                        end
                        default: begin
                            res_rgb_reg <= '0;
                            res_st_reg  <= plt_pkg::ST_OK;
                            state_reg   <= S_DONE;
                        end
                    endcase
                end
                S_DIV: begin
                    if (div_done) begin
                        e1_reg    <= div_rem[AW-1:0];
                        state_reg <= S_RD2;
                    end
                end
                S_RD2: begin
                    c1_reg    <= mem_rdata;
                    state_reg <= S_BLEND;
                end
                S_BLEND: begin
                    state_reg <= S_BLENDW;
                end
                S_BLENDW: begin
                    // direct reads and negative-position lookups take the memory word, interpolated lookups the blend
                    res_rgb_reg <= (cmd_reg == plt_pkg::CMD_LOOKUP && !idx_reg[31])
                                   ? blend_rgb : mem_rdata;
                    state_reg   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_tdata_reg  <= {res_rgb_reg[7:0], res_rgb_reg[15:8],
                                         res_rgb_reg[23:16]};
                        m_tuser_reg  <= res_st_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[hw/rtl/plt_ram.sv]
// palette colour store: one address port shared by write and read, registered read data
// depends on plt_pkg for the colour width
module plt_ram #(
    parameter int DEPTH = plt_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [AW-1:0]              addr,
    input  logic [plt_pkg::RGB_W-1:0]  wdata,
    output logic [plt_pkg::RGB_W-1:0]  rdata
);

    logic [plt_pkg::RGB_W-1:0] mem [DEPTH];
    logic [plt_pkg::RGB_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/plt_mod.sv]
// serial remainder unit: dividend modulo palette entry count, radix 4
// depends on plt_pkg for the dividend width and step count
module plt_mod #(
    parameter int CW = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [plt_pkg::DIV_BITS-1:0]  dividend,
    input  logic [CW-1:0]                 divisor,
    output logic                          done,
    output logic [CW-1:0]                 rem
);

    logic                          busy_reg;
    logic [plt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [plt_pkg::DIV_BITS-1:0]  shift_reg;
    logic [CW-1:0]                 rem_reg;
    logic [CW-1:0]                 div_reg;
    logic [CW-1:0]                 rem_next;

    // two restoring steps; remainder stays below the divisor
    always_comb begin
        logic [CW:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < plt_pkg::DIV_RADIX; i++) begin
            t = {rem_next, shift_reg[plt_pkg::DIV_BITS-1-i]};
            if (t >= {1'b0, div_reg}) begin
                t = t - {1'b0, div_reg};
            end
            rem_next = t[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            cnt_reg   <= plt_pkg::DIV_CNT_W'(plt_pkg::DIV_STEPS);
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                cnt_reg   <= cnt_reg - plt_pkg::DIV_CNT_W'(1);
                shift_reg <= shift_reg << plt_pkg::DIV_RADIX;
                rem_reg   <= rem_next;
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign rem  = rem_reg;

endmodule

[hw/rtl/plt_blend.sv]
// per-channel linear blend of two palette colours by an 8-bit fraction
// depends on plt_pkg for the colour width; result is registered
module plt_blend (
    input  logic                       aclk,
    input  logic [plt_pkg::RGB_W-1:0]  c1,
    input  logic [plt_pkg::RGB_W-1:0]  c2,
    input  logic [7:0]                 frac,
    output logic [plt_pkg::RGB_W-1:0]  rgb
);

    // a*(256-f) + b*f never exceeds 255*256, so bits 15:8 are the floor
    function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] f);
        logic [8:0]  wa;
        logic [16:0] num;
        wa  = 9'd256 - {1'b0, f};
        num = 17'(a) * 17'(wa) + 17'(b) * 17'(f);
        return num[15:8];
    endfunction

    logic [plt_pkg::RGB_W-1:0] rgb_reg;

    always_ff @(posedge aclk) begin
        rgb_reg <= {blend_ch(c1[23:16], c2[23:16], frac),
                    blend_ch(c1[15:8],  c2[15:8],  frac),
                    blend_ch(c1[7:0],   c2[7:0],   frac)};
    end

    assign rgb = rgb_reg;

endmodule

[hw/rtl/plt_check.sv]
// port-level checks for the palette interpolating lookup
// depends on plt_pkg; bound to the top level below
module plt_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [plt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [1:0]                    m_tuser
);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one command at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");

    // full status only comes from an append, which carries no colour
    a_full_no_colour: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == plt_pkg::ST_FULL |-> m_tdata == '0)
        else $error("full status with colour");

    // empty palette reads give white
    a_empty_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == plt_pkg::ST_EMPTY |-> m_tdata == plt_pkg::WHITE)
        else $error("empty status without white");

endmodule

bind palette_interpolating_lookup plt_check u_plt_check (.*);
